FILE: rtl/pefp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Echo frame parser package
// Shared types and constants for the power echo frame parser.
// ----------------------------------------------------------------------------
package pefp_pkg;

  localparam int unsigned FrameLengthDefault = 39;

  // Payload offset counter width; covers frame lengths up to 64.
  localparam int unsigned IdxW   = 6;
  localparam int unsigned IdW    = 5;
  localparam int unsigned ValueW = 16;

  localparam logic [7:0] SyncChar = 8'h50;
  localparam logic [7:0] SyncLast = 8'd11;

  localparam logic [IdxW-1:0] OfsSwitchFirst = IdxW'(3);
  localparam logic [IdxW-1:0] OfsSwitchLast  = IdxW'(9);
  localparam logic [IdxW-1:0] OfsWordFirst   = IdxW'(10);
  localparam logic [IdxW-1:0] OfsWordLast    = IdxW'(37);
  localparam logic [IdxW-1:0] OfsConnected   = IdxW'(38);

  localparam logic [IdW-1:0] IdConnected = IdW'(18);

  typedef enum logic [2:0] {
    SYNC_P0,
    SYNC_P1,
    SYNC_P2,
    SYNC_END,
    PAYLOAD
  } sync_stage_e;

endpackage : pefp_pkg
`default_nettype wire

FILE: rtl/pefp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Echo frame parser input channel
// Valid/ready channel carrying one received byte or a timeout event.
// ----------------------------------------------------------------------------
interface pefp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface : pefp_in_if
`default_nettype wire

FILE: rtl/pefp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Echo frame parser output channel
// Valid/ready channel carrying one parsed field of an echo frame.
// ----------------------------------------------------------------------------
interface pefp_out_if;
  import pefp_pkg::*;
  logic              valid;
  logic              ready;
  logic [IdW-1:0]    field_id;
  logic [ValueW-1:0] field_value;
  logic              frame_end;

  modport source (output valid, output field_id, output field_value, output frame_end,
                  input ready);
  modport sink   (input valid, input field_id, input field_value, input frame_end,
                  output ready);
endinterface : pefp_out_if
`default_nettype wire

FILE: rtl/power_echo_frame_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Power echo frame parser
// Parses echo frames ('P','P','P',11 then a fixed payload) from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per received byte (action = 0) or per read timeout
//   (action = 1). out_o carries the parsed fields: four switch states, fourteen
//   big-endian housekeeping words and the connected flag, which has frame_end
//   set. Sync bytes and high halves of words produce no output word.
//   A word is registered on entry, then handled in one pass that updates the
//   sync and payload state and loads the result register that drives out_o.
//   One word is accepted per cycle as long as the result register is empty
//   or being drained. When the receiver stalls, the result register holds,
//   the entry register fills behind it and then in_i.ready drops; nothing is
//   lost or dropped. Reset clears both registers' valid flags and returns
//   the parser to waiting for the first sync byte.
// ----------------------------------------------------------------------------
module power_echo_frame_parser_unit
  import pefp_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = FrameLengthDefault
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  pefp_in_if.sink   in_i,
  pefp_out_if.source out_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_LENGTH - 1);

  // Entry register.
  logic       in_valid_q;
  logic       action_q;
  logic [7:0] byte_q;

  // Parser state.
  sync_stage_e     stage_q, stage_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      high_q, high_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [ValueW-1:0] value_q, value_d;
  logic              end_q, end_d;

  logic            advance;
  logic [7:0]      b;
  logic [7:0]      want;
  logic [IdxW-1:0] idx_rel;

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;

  assign b       = action_q ? 8'd0 : byte_q;
  assign want    = (stage_q == SYNC_END) ? SyncLast : SyncChar;
  // Switch and word ids both follow (offset - 3) / 2.
  assign idx_rel = idx_q - OfsSwitchFirst;

  always_comb begin
    stage_d     = stage_q;
    idx_d       = idx_q;
    high_d      = high_q;
    out_valid_d = 1'b0;
    id_d        = '0;
    value_d     = '0;
    end_d       = 1'b0;

    if (stage_q != PAYLOAD) begin
      if (action_q) begin
        stage_d = SYNC_P0;
      end else if (b == want) begin
        stage_d = sync_stage_e'(stage_q + 3'd1);
        idx_d   = '0;
      end
    end else begin
      if (idx_q >= OfsSwitchFirst && idx_q <= OfsSwitchLast && idx_q[0]) begin
        out_valid_d = 1'b1;
        id_d        = IdW'(idx_rel >> 1);
        value_d     = {8'd0, b};
      end else if (idx_q >= OfsWordFirst && idx_q <= OfsWordLast) begin
        if (!idx_q[0]) begin
          high_d = b;
        end else begin
          out_valid_d = 1'b1;
          id_d        = IdW'(idx_rel >> 1);
          value_d     = {high_q, b};
        end
      end else if (idx_q == OfsConnected) begin
        out_valid_d = 1'b1;
        id_d        = IdConnected;
        value_d     = {15'd0, (b != 8'd0)};
        end_d       = 1'b1;
      end

      if (idx_q >= LastIdx) begin
        stage_d = SYNC_P0;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      stage_q     <= SYNC_P0;
      idx_q       <= '0;
      high_q      <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && out_valid_d;
        if (in_valid_q) begin
          stage_q <= stage_d;
          idx_q   <= idx_d;
          high_q  <= high_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      action_q <= in_i.action;
      byte_q   <= in_i.data_byte;
    end
    if (advance && in_valid_q && out_valid_d) begin
      id_q    <= id_d;
      value_q <= value_d;
      end_q   <= end_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.field_id    = id_q;
  assign out_o.field_value = value_q;
  assign out_o.frame_end   = end_q;

  // The frame end mark only ever rides on the connected flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && end_q |-> id_q == IdConnected)
    else $error("frame_end on a field other than connected");

  // The payload offset is parked at zero whenever the parser is in sync.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q != PAYLOAD |-> idx_q == '0)
    else $error("payload offset nonzero during sync");

  // A new entry word is never taken while the held one cannot move on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> !in_i.ready)
    else $error("entry register overwritten while stalled");

endmodule : power_echo_frame_parser_unit
`default_nettype wire

FILE: tb/sv/pefp_field_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo frame parser field checker
// Watches both channels of the parser. Every accepted input word goes
// through a local model of the sync and payload logic. Each field that the
// model expects is queued and compared with the next field the parser
// delivers.
// ----------------------------------------------------------------------------
module pefp_field_checker
  import pefp_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = FrameLengthDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  pefp_in_if          in_mon_i,
  pefp_out_if         out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned fields_seen_o,
  output int unsigned frame_ends_o
);

  // Housekeeping words follow the four switch states in the id space.
  localparam logic [IdW-1:0] IdWordFirst = IdW'(4);

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ValueW-1:0] value;
    logic              last;
  } field_t;

  field_t          expected_fields[$];
  field_t          want;
  field_t          got;
  sync_stage_e     stage;
  logic [IdxW-1:0] offset;
  logic [7:0]      high_byte;
  int unsigned     fails;
  int unsigned     fields_seen;
  int unsigned     frame_ends;

  // Advances the local parser by one word; returns 1 when a field is due.
  function automatic bit parse_word(input logic timed_out, input logic [7:0] rx,
                                    output field_t fld);
    logic [7:0]      b;
    logic [IdxW-1:0] idx;
    bit              has_field;
    b         = timed_out ? 8'h00 : rx;
    idx       = offset;
    has_field = 1'b0;
    fld       = '0;
    if (stage != PAYLOAD) begin
      // A timeout drops any partial sync; a byte that does not match is skipped.
      if (timed_out) begin
        stage = SYNC_P0;
      end else if (b == ((stage == SYNC_END) ? SyncLast : SyncChar)) begin
        stage  = sync_stage_e'(stage + 1);
        offset = '0;
      end
      return 1'b0;
    end
    if (idx >= OfsSwitchFirst && idx <= OfsSwitchLast) begin
      if (idx[0]) begin
        has_field = 1'b1;
        fld.id    = IdW'((idx - OfsSwitchFirst) >> 1);
        fld.value = ValueW'(b);
      end
    end else if (idx >= OfsWordFirst && idx <= OfsWordLast) begin
      if (!idx[0]) begin
        high_byte = b;
      end else begin
        has_field = 1'b1;
        fld.id    = IdWordFirst + IdW'((idx - OfsWordFirst) >> 1);
        fld.value = {high_byte, b};
      end
    end else if (idx == OfsConnected) begin
      has_field = 1'b1;
      fld.id    = IdConnected;
      fld.value = ValueW'(b != 8'h00);
      fld.last  = 1'b1;
    end
    if (32'(idx) + 1 >= FRAME_LENGTH) begin
      stage  = SYNC_P0;
      offset = '0;
    end else begin
      offset = idx + 1'b1;
    end
    return has_field;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage     = SYNC_P0;
      offset    = '0;
      high_byte = '0;
      expected_fields.delete();
      fails       = 0;
      fields_seen = 0;
      frame_ends  = 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (parse_word(in_mon_i.action, in_mon_i.data_byte, want)) begin
          expected_fields.push_back(want);
        end
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = '{id: out_mon_i.field_id, value: out_mon_i.field_value,
                last: out_mon_i.frame_end};
        fields_seen++;
        if (got.last) frame_ends++;
        if (expected_fields.size() == 0) begin
          $display("%0t: unexpected field: expected none, got id %0d value 0x%04h end %0b",
                   $time, got.id, got.value, got.last);
          fails++;
        end else begin
          want = expected_fields.pop_front();
          if (got !== want) begin
            if (got.id !== want.id)
              $display("%0t: field_id mismatch: expected %0d, got %0d",
                       $time, want.id, got.id);
            if (got.value !== want.value)
              $display("%0t: field_value mismatch (id %0d): expected 0x%04h, got 0x%04h",
                       $time, want.id, want.value, got.value);
            if (got.last !== want.last)
              $display("%0t: frame_end mismatch (id %0d): expected %0b, got %0b",
                       $time, want.id, want.last, got.last);
            fails++;
          end
        end
      end
    end
    fail_count_o  <= fails;
    pending_o     <= expected_fields.size();
    fields_seen_o <= fields_seen;
    frame_ends_o  <= frame_ends;
  end

endmodule : pefp_field_checker

FILE: tb/sv/tb_power_echo_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power echo frame parser testbench
// Feeds the parser a directed sync and frame sequence, then mostly complete
// frames with random payload, timeouts and line noise, under three patterns
// of sender gaps and receiver stalls. The field checker judges every word.
// ----------------------------------------------------------------------------
module tb_power_echo_frame_parser_unit;
  import pefp_pkg::*;

  localparam int unsigned FrameLen      = FrameLengthDefault;
  localparam int unsigned ItemsPerPhase = 650;
  localparam int unsigned DrainCycles   = 16;
  localparam logic        ActByte       = 1'b0;
  localparam logic        ActTimeout    = 1'b1;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned words_sent;
  int unsigned frame_words;
  int unsigned frames_sent;
  int unsigned sync_aborts;
  int unsigned payload_timeouts;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned fields_seen;
  int unsigned frame_ends;

  pefp_in_if  in_ch ();
  pefp_out_if out_ch ();

  always #5 clk_i = ~clk_i;

  power_echo_frame_parser_unit #(
    .FRAME_LENGTH(FrameLen)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  pefp_field_checker #(
    .FRAME_LENGTH(FrameLen)
  ) u_field_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .fields_seen_o(fields_seen),
    .frame_ends_o (frame_ends)
  );

  // Biased toward the sync characters and the byte extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return SyncChar;
      1: return SyncLast;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Returns at the edge where the word is taken.
  task automatic send_word(input logic act, input logic [7:0] dat);
    if ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_gap_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= dat;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  initial begin : sink_side
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= rst_ni && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned tmo_pct;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ActByte;
    in_ch.data_byte <= 8'h00;
    src_gap_pct      = 11;
    sink_stall_pct   = 85;
    words_sent       = 0;
    frame_words      = 0;
    frames_sent      = 0;
    sync_aborts      = 0;
    payload_timeouts = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Stray bytes before sync, a timeout that aborts a partial sync, and
    // a surplus 'P' byte skipped while the final sync byte is awaited.
    send_word(ActByte, 8'h00);
    send_word(ActByte, 8'hFF);
    send_word(ActByte, SyncChar);
    send_word(ActByte, SyncChar);
    send_word(ActTimeout, 8'hFF);
    repeat (4) send_word(ActByte, SyncChar);
    send_word(ActByte, SyncLast);
    // All-ones fields, then all-zero fields, with a timeout standing in for a
    // low byte and a small nonzero connected byte.
    for (int off = 0; off < FrameLen; off++) begin
      if (off == 21) send_word(ActTimeout, 8'hFF);
      else if (off == OfsConnected) send_word(ActByte, 8'h01);
      else send_word(ActByte, (off < 20) ? 8'hFF : 8'h00);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_gap_pct    = 11;
          sink_stall_pct = 85;
        end
        1: begin
          src_gap_pct    = 85;
          sink_stall_pct = 11;
        end
        default: begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end
      endcase
      target = frame_words + ItemsPerPhase;
      while (frame_words < target) begin
        case ($urandom_range(9))
          0: begin
            // Partial sync cut off by a timeout.
            repeat ($urandom_range(1, 3)) send_word(ActByte, SyncChar);
            send_word(ActTimeout, pick_byte());
            sync_aborts++;
          end
          1: begin
            repeat ($urandom_range(1, 4)) begin
              if ($urandom_range(3) == 0) send_word(ActTimeout, pick_byte());
              else send_word(ActByte, pick_byte());
            end
          end
          default: begin
            case ($urandom_range(3))
              0: tmo_pct = 0;
              1: tmo_pct = 25;
              default: tmo_pct = 3;
            endcase
            repeat ($urandom_range(0, 2)) send_word(ActByte, pick_byte());
            for (int s = 0; s < 4; s++) begin
              // Occasionally a byte that the current sync stage must skip.
              if ($urandom_range(9) == 0) send_word(ActByte, (s < 3) ? SyncLast : SyncChar);
              send_word(ActByte, (s < 3) ? SyncChar : SyncLast);
            end
            for (int off = 0; off < FrameLen; off++) begin
              if ($urandom_range(99) < tmo_pct) begin
                send_word(ActTimeout, pick_byte());
                payload_timeouts++;
              end else if (off == OfsConnected && $urandom_range(2) == 0) begin
                send_word(ActByte, 8'h00);
              end else begin
                send_word(ActByte, pick_byte());
              end
            end
            frames_sent++;
            frame_words += 4 + FrameLen;
          end
        endcase
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d words: %0d random frames, %0d aborted syncs, %0d payload timeouts.",
             words_sent, frames_sent, sync_aborts, payload_timeouts);
    $display("Checked %0d fields and %0d frame ends under three gap and stall patterns.",
             fields_seen, frame_ends);
    if (fail_count == 0) begin
      $display("PASS power_echo_frame_parser_unit");
    end else begin
      $display("FAIL power_echo_frame_parser_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timed out with %0d fields still outstanding.", pending);
    $display("FAIL power_echo_frame_parser_unit");
    $finish;
  end

endmodule : tb_power_echo_frame_parser_unit
